// ----- hw/rtl/index_primitive_serializer_core_defines.svh -----
// Assertion macros for the index primitive serialiser.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef INDEX_PRIMITIVE_SERIALIZER_CORE_DEFINES_SVH
`define INDEX_PRIMITIVE_SERIALIZER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define IPS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ips assertion failed");
`define IPS_ASSERT_NEVER(lbl, clk, rstn, expr) \
  `IPS_ASSERT(lbl, clk, rstn, !(expr))
`else
`define IPS_ASSERT(lbl, clk, rstn, prop)
`define IPS_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ----- hw/rtl/ips_pkg.sv -----
// Shared types and constants of the index primitive serialiser.
// No dependencies.
package ips_pkg;

  typedef enum logic [2:0] {
    OP_INT32  = 3'd0,
    OP_INT64  = 3'd1,
    OP_VINT32 = 3'd2,
    OP_VINT64 = 3'd3,
    OP_CHAR   = 3'd4
  } op_e;

  typedef enum logic {
    MODE_BE  = 1'b0,
    MODE_VAR = 1'b1
  } mode_e;

  localparam int unsigned CntW = 4;

  typedef struct packed {
    logic              ok;
    mode_e             mode;
    logic [63:0]       val;
    logic [CntW-1:0]   cnt;
  } load_t;

  typedef struct packed {
    logic [7:0]        data;
    logic              last;
    logic [63:0]       val;
    logic [CntW-1:0]   cnt;
  } step_t;

endpackage

// ----- hw/rtl/ips_loader.sv -----
// Item loader: turns opcode and value into the working word and byte count.
// Depends on ips_pkg.
module ips_loader (
  input  logic [2:0]     opcode_i,
  input  logic [63:0]    value_i,
  output ips_pkg::load_t load_o
);
  import ips_pkg::*;

  logic [15:0] ch;

  assign ch = value_i[15:0];

  always_comb begin
    load_o = '{ok: 1'b1, mode: MODE_BE, val: '0, cnt: '0};
    case (opcode_i)
      OP_INT32: begin
        load_o.val = {value_i[31:0], 32'h0};
        load_o.cnt = CntW'(4);
      end
      OP_INT64: begin
        load_o.val = value_i;
        load_o.cnt = CntW'(8);
      end
      OP_VINT32: begin
        load_o.mode = MODE_VAR;
        load_o.val  = {32'h0, value_i[31:0]};
      end
      OP_VINT64: begin
        load_o.mode = MODE_VAR;
        load_o.val  = value_i;
      end
      OP_CHAR: begin
        if (ch != 16'h0 && ch <= 16'h007F) begin
          load_o.val = {ch[7:0], 56'h0};
          load_o.cnt = CntW'(1);
        end else if (ch <= 16'h07FF) begin
          load_o.val = {3'b110, ch[10:6], 2'b10, ch[5:0], 48'h0};
          load_o.cnt = CntW'(2);
        end else begin
          load_o.val = {4'b1110, ch[15:12], 2'b10, ch[11:6], 2'b10, ch[5:0], 40'h0};
          load_o.cnt = CntW'(3);
        end
      end
      default: begin
        load_o.ok = 1'b0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/ips_byte_unit.sv -----
// Shared shift unit: emits one byte per step, shifting the working word by a byte (big-endian) or seven bits (varint).
// Depends on ips_pkg.
module ips_byte_unit (
  input  ips_pkg::mode_e            mode_i,
  input  logic [63:0]               val_i,
  input  logic [ips_pkg::CntW-1:0]  cnt_i,
  output ips_pkg::step_t            step_o
);
  import ips_pkg::*;

  logic more;

  assign more = |val_i[63:7];

  always_comb begin
    case (mode_i)
      MODE_VAR: begin
        step_o.data = {more, val_i[6:0]};
        step_o.last = ~more;
        step_o.val  = {7'h0, val_i[63:7]};
        step_o.cnt  = cnt_i;
      end
      default: begin
        step_o.data = val_i[63:56];
        step_o.last = (cnt_i == CntW'(1));
        step_o.val  = {val_i[55:0], 8'h0};
        step_o.cnt  = CntW'(cnt_i - CntW'(1));
      end
    endcase
  end

endmodule

// ----- hw/rtl/index_primitive_serializer_core.sv -----
// Index primitive serialiser: one opcode and value in, its serialised bytes out.
// Input channel: in_valid_i / in_stall_o with opcode_i and value_i. Output channel:
// out_valid_o / out_stall_i with out_byte_o and last_o, last_o set on the final
// word of an item. A word moves at a clock edge where valid is high and stall low.
// Opcodes: 0 int32 big-endian (4 words), 1 int64 big-endian (8 words), 2 varint32
// (1..5), 3 varint64 (1..10), 4 modified UTF-8 character (1..3). Opcodes 5..7 are
// taken and dropped without output.
// One shared shift unit produces one word per cycle into the output register while the
// receiver does not stall: an item is first loaded into the working registers, then
// shifted out one word per shift step; in_stall_o stays high while an item is being
// shifted out. The first word reaches the output register in the first shift step.
// A stalled receiver holds the output register and with it the shift sequence.
// The input is free again once the final word sits in the output register.
// Reset empties the output register and returns the sequencer to idle.
// Depends on ips_pkg, ips_loader, ips_byte_unit and the defines header.
`include "index_primitive_serializer_core_defines.svh"

module index_primitive_serializer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [63:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);
  import ips_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  state_e          state_q, state_d;
  mode_e           mode_q;
  logic [63:0]     val_q;
  logic [CntW-1:0] cnt_q;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q;
  logic            last_q;

  load_t load;
  step_t step;
  logic  in_acc;
  logic  out_free;
  logic  do_step;

  ips_loader u_loader (
    .opcode_i (opcode_i),
    .value_i  (value_i),
    .load_o   (load)
  );

  ips_byte_unit u_byte_unit (
    .mode_i (mode_q),
    .val_i  (val_q),
    .cnt_i  (cnt_q),
    .step_o (step)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign do_step    = (state_q == S_RUN) & out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && load.ok) state_d = S_RUN;
      end
      S_RUN: begin
        if (do_step && step.last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (do_step) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= load.mode;
      val_q  <= load.val;
      cnt_q  <= load.cnt;
    end else if (do_step) begin
      val_q  <= step.val;
      cnt_q  <= step.cnt;
    end
    if (do_step) begin
      out_byte_q <= step.data;
      last_q     <= step.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

  `IPS_ASSERT(a_load_runs, clk_i, rst_ni, (in_acc && load.ok) |=> (state_q == S_RUN))
  `IPS_ASSERT(a_last_idles, clk_i, rst_ni, (do_step && step.last) |=> (state_q == S_IDLE && out_valid_o && last_o))
  `IPS_ASSERT_NEVER(a_be_cnt_live, clk_i, rst_ni, state_q == S_RUN && mode_q == MODE_BE && cnt_q == '0)
  `IPS_ASSERT(a_bad_op_drop, clk_i, rst_ni, (in_acc && !load.ok) |=> (state_q == S_IDLE))

endmodule

// ----- bench/index_primitive_serializer_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for index_primitive_serializer_core: a directed table, then random
// items under three flow-control phases, each output word checked against typed bytes or a local encoder.
// Depends on ips_pkg and the serialiser RTL.
module index_primitive_serializer_core_tb;
  import ips_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_ITEMS = 420;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int USE_ENCODER  = -1;

  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  typedef struct {
    logic [2:0]  op;
    logic [63:0] val;
    int          n_typed;
    logic [79:0] bytes;
  } stim_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [2:0]  opcode_i    = '0;
  logic [63:0] value_i     = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        last_o;

  out_word_t   expected_words[$];
  stim_row_t   stim_rows[$];
  out_word_t   head_word;
  int          send_idle_pct  = 8;
  int          recv_stall_pct = 52;
  int          error_count    = 0;
  int          words_checked  = 0;
  int          ignored_items  = 0;
  int          cycle_count    = 0;

  index_primitive_serializer_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic void push_expected(input logic [7:0] data, input logic last);
    out_word_t w;
    w.data = data;
    w.last = last;
    expected_words.push_back(w);
  endfunction

  function automatic void serialise_item(input logic [2:0] op, input logic [63:0] val);
    logic [7:0]  seq[$];
    logic [63:0] v;
    logic [15:0] c;
    case (op)
      OP_INT32: for (int i = 3; i >= 0; i--) seq.push_back(val[8*i +: 8]);
      OP_INT64: for (int i = 7; i >= 0; i--) seq.push_back(val[8*i +: 8]);
      OP_VINT32, OP_VINT64: begin
        v = (op == OP_VINT32) ? {32'd0, val[31:0]} : val;
        while (v > 64'h7F) begin
          seq.push_back({1'b1, v[6:0]});
          v = v >> 7;
        end
        seq.push_back(v[7:0]);
      end
      OP_CHAR: begin
        c = val[15:0];
        if (c != 16'd0 && c <= 16'h7F) begin
          seq.push_back(c[7:0]);
        end else if (c <= 16'h7FF) begin
          seq.push_back({3'b110, c[10:6]});
          seq.push_back({2'b10, c[5:0]});
        end else begin
          seq.push_back({4'b1110, c[15:12]});
          seq.push_back({2'b10, c[11:6]});
          seq.push_back({2'b10, c[5:0]});
        end
      end
      default: ;
    endcase
    foreach (seq[i]) push_expected(seq[i], i == seq.size() - 1);
  endfunction

  task automatic add_row(input logic [2:0] op, input logic [63:0] val, input int n_typed,
                         input logic [79:0] bytes);
    stim_row_t r;
    r.op      = op;
    r.val     = val;
    r.n_typed = n_typed;
    r.bytes   = bytes;
    stim_rows.push_back(r);
  endtask

  function automatic stim_row_t random_row();
    stim_row_t r;
    int        w;
    r.n_typed = USE_ENCODER;
    r.bytes   = '0;
    r.val     = {$urandom, $urandom};
    if ($urandom_range(99) < 6) begin
      r.op = 3'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
    end else begin
      r.op = 3'($urandom_range(OP_CHAR, OP_INT32));
    end
    if (r.op == OP_CHAR) begin
      case ($urandom_range(3))
        0: r.val[15:0] = 16'd0;
        1: r.val[15:0] = 16'($urandom_range(16'h7F, 1));
        2: r.val[15:0] = 16'($urandom_range(16'h7FF, 16'h80));
        default: r.val[15:0] = 16'($urandom_range(16'hFFFF, 16'h800));
      endcase
    end else if ($urandom_range(3) != 0) begin
      w = $urandom_range(64);
      if (w < 64) r.val = r.val & ((64'd1 << w) - 64'd1);
    end
    return r;
  endfunction

  task automatic send_word(input stim_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= row.op;
    value_i    <= row.val;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    if (row.op >= OP_RSVD_LO) ignored_items++;
    if (row.n_typed == USE_ENCODER) begin
      serialise_item(row.op, row.val);
    end else begin
      for (int k = 0; k < row.n_typed; k++) begin
        push_expected(row.bytes[8*(row.n_typed-1-k) +: 8], k == row.n_typed - 1);
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o !== 1'b0 && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, got byte %h last %b",
                 $time, out_byte_o, last_o);
        error_count++;
      end else begin
        head_word = expected_words.pop_front();
        if (out_byte_o !== head_word.data) begin
          $display("%0t: out_byte mismatch, expected %h, got %h",
                   $time, head_word.data, out_byte_o);
          error_count++;
        end
        if (last_o !== head_word.last) begin
          $display("%0t: last mismatch, expected %b, got %b",
                   $time, head_word.last, last_o);
          error_count++;
        end
        words_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out after %0d cycles", $time, CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    int        valid_items;
    int        directed_items;

    add_row(OP_INT32,  64'h0000_0000_1234_5678, 4, 80'h12_34_56_78);
    add_row(OP_INT32,  64'hFFFF_FFFF_0000_0000, 4, 80'h00_00_00_00);
    add_row(OP_INT64,  64'h0102_0304_0506_0708, 8, 80'h01_02_03_04_05_06_07_08);
    add_row(OP_INT64,  64'hFFFF_FFFF_FFFF_FFFF, 8, 80'hFF_FF_FF_FF_FF_FF_FF_FF);
    add_row(OP_VINT32, 64'h0,                   1, 80'h00);
    add_row(OP_VINT32, 64'h7F,                  1, 80'h7F);
    add_row(OP_VINT32, 64'h80,                  2, 80'h80_01);
    add_row(OP_VINT32, 64'hFFFF_FFFF,           5, 80'hFF_FF_FF_FF_0F);
    add_row(OP_VINT32, 64'hABCD_0000_0000_0001, 1, 80'h01);
    add_row(OP_VINT64, 64'h0,                   1, 80'h00);
    add_row(OP_VINT64, 64'hFFFF_FFFF_FFFF_FFFF, 10, 80'hFF_FF_FF_FF_FF_FF_FF_FF_FF_01);
    add_row(OP_VINT64, 64'h8000_0000_0000_0000, USE_ENCODER, '0);
    add_row(OP_VINT64, 64'h3FFF,                USE_ENCODER, '0);
    add_row(OP_CHAR,   64'h0,                   2, 80'hC0_80);
    add_row(OP_CHAR,   64'h41,                  1, 80'h41);
    add_row(OP_CHAR,   64'h7F,                  1, 80'h7F);
    add_row(OP_CHAR,   64'h80,                  2, 80'hC2_80);
    add_row(OP_CHAR,   64'h7FF,                 2, 80'hDF_BF);
    add_row(OP_CHAR,   64'h800,                 3, 80'hE0_A0_80);
    add_row(OP_CHAR,   64'hD800,                USE_ENCODER, '0);
    add_row(OP_CHAR,   64'hFFFF,                3, 80'hEF_BF_BF);
    add_row(OP_CHAR,   64'hFFFF_FFFF_FFFF_0001, 1, 80'h01);
    add_row(OP_RSVD_LO, 64'h1234,               0, '0);
    add_row(OP_RSVD_HI, 64'hFFFF_FFFF_FFFF_FFFF, 0, '0);
    directed_items = stim_rows.size();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) send_word(stim_rows[i]);

    valid_items = 0;
    while (valid_items < RANDOM_ITEMS) begin
      if (valid_items == RANDOM_ITEMS / 3) begin
        send_idle_pct  = 52;
        recv_stall_pct = 8;
      end else if (valid_items == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      row = random_row();
      send_word(row);
      if (row.op < OP_RSVD_LO) valid_items++;
    end
    in_valid_i <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d directed and %0d random encodable items, %0d undefined opcodes dropped;",
             directed_items, RANDOM_ITEMS, ignored_items);
    $display("%0d output words compared over three flow-control phases.", words_checked);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
